### hdl/gng_pkg.sv
// shared types, constants and arithmetic helpers of the gradient noise generator
// no dependencies
package gng_pkg;

  localparam int TableSize = 256;
  localparam int AddrW     = $clog2(TableSize);
  localparam int FracBits  = 16;
  localparam int CoordW    = 24;
  localparam int CellW     = CoordW - FracBits;
  localparam int OutW      = 20;
  localparam int ValW      = 21;
  localparam int FadeW     = 24;
  localparam int DimsW     = 3;
  localparam int NumAxes   = 4;
  localparam int NumCorner = 16;

  typedef logic [7:0]              hash_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [FracBits-1:0]     frac_t;
  typedef logic [CellW-1:0]        cell_t;
  typedef logic [CoordW-1:0]       coord_t;
  typedef logic [DimsW-1:0]        dims_t;
  typedef logic signed [ValW-1:0]  val_t;
  typedef logic signed [FadeW-1:0] fade_t;
  typedef logic signed [OutW-1:0]  noise_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  localparam dims_t DimsReset = dims_t'(3);
  localparam dims_t Dims1     = dims_t'(1);
  localparam dims_t Dims2     = dims_t'(2);
  localparam dims_t Dims3     = dims_t'(3);
  localparam dims_t Dims4     = dims_t'(4);

  localparam val_t  ValOne  = val_t'(1 << FracBits);
  localparam fade_t Fade15  = fade_t'(15 * (1 << FracBits));
  localparam fade_t Fade10  = fade_t'(10 * (1 << FracBits));
  localparam val_t  OutMax  = val_t'((1 << (OutW - 1)) - 1);
  localparam val_t  OutMin  = -val_t'(1 << (OutW - 1));

  localparam int FadeProdW = FadeW + FracBits + 2;
  localparam int LerpProdW = FadeW + ValW + 1;

  // floor((f * r) / 2^FracBits)
  function automatic fade_t fade_mul(input frac_t f, input fade_t r);
    logic signed [FadeProdW-1:0] p;
    logic signed [FadeProdW-1:0] sh;
    p  = $signed({2'b00, f}) * r;
    sh = p >>> FracBits;
    return sh[FadeW-1:0];
  endfunction

  // first fade step: 6f - 15
  function automatic fade_t fade_first(input frac_t f);
    fade_t fs;
    fs = fade_t'({{(FadeW - FracBits){1'b0}}, f});
    return fade_t'((fs <<< 2) + (fs <<< 1)) - Fade15;
  endfunction

  // a + floor(t * (b - a) / 2^FracBits)
  function automatic val_t lerp_f(input val_t a, input val_t b, input fade_t t);
    logic signed [ValW:0]         diff;
    logic signed [LerpProdW-1:0]  p;
    logic signed [LerpProdW-1:0]  sh;
    diff = {b[ValW-1], b} - {a[ValW-1], a};
    p    = t * diff;
    sh   = p >>> FracBits;
    return a + sh[ValW-1:0];
  endfunction

  // corner gradient dotted with offsets
  function automatic val_t grad_f(input dims_t dims, input hash_t hash,
                                  input val_t d0, input val_t d1,
                                  input val_t d2, input val_t d3);
    logic [4:0] h;
    val_t u, v, c;
    h = 5'd0;
    u = d0;
    v = d1;
    c = d2;
    case (dims)
      Dims1: begin
        return hash[0] ? d0 : -d0;
      end
      Dims2: begin
        return (hash[0] ? d0 : -d0) + (hash[1] ? d1 : -d1);
      end
      Dims3: begin
        h = {1'b0, hash[3:0]};
        u = (h < 5'd8) ? d0 : d1;
        v = (h < 5'd4) ? d1 : ((h == 5'd12 || h == 5'd14) ? d0 : d2);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
      end
      default: begin
        h = hash[4:0];
        u = (h < 5'd24) ? d0 : d1;
        v = (h < 5'd16) ? d1 : d2;
        c = (h < 5'd8) ? d2 : d3;
        return (h[0] ? -u : u) + (h[1] ? -v : v) + (h[2] ? -c : c);
      end
    endcase
  endfunction

endpackage

### hdl/gng_in_if.sv
// request channel of the noise generator: valid, ready and the item fields
// depends on gng_pkg
interface gng_in_if import gng_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   op;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;
  coord_t coord_w;
  hash_t  table_index;
  hash_t  table_value;

  modport source (output valid, op, coord_x, coord_y, coord_z, coord_w,
                  table_index, table_value, input ready);
  modport sink   (input valid, op, coord_x, coord_y, coord_z, coord_w,
                  table_index, table_value, output ready);
endinterface

### hdl/gng_out_if.sv
// result channel of the noise generator: valid, ready and the noise value
// depends on gng_pkg
interface gng_out_if import gng_pkg::*; ();
  logic   valid;
  logic   ready;
  noise_t noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

### hdl/gng_ram.sv
// generic memory: one write port, two read ports with registered data
// no dependencies
module gng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hdl/gng_hash.sv
// hash chain: four levels of permutation table copies, one level per stage
// depends on gng_pkg and gng_ram; loads write each copy at its own stage
module gng_hash import gng_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  load_i,
  input  addr_t index_i,
  input  hash_t value_i,
  input  cell_t cell_x_i,
  input  cell_t cell_y_i,
  input  cell_t cell_z_i,
  input  cell_t cell_w_i,
  output hash_t h1_o [2],
  output hash_t h2_o [4],
  output hash_t h3_o [8],
  output hash_t h4_o [16]
);

  // load requests travel with the pipeline
  logic  wr_q [1:3];
  addr_t idx_q [1:3];
  hash_t val_q [1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q[1] <= 1'b0;
      wr_q[2] <= 1'b0;
      wr_q[3] <= 1'b0;
    end else if (adv_i) begin
      wr_q[1] <= load_i;
      wr_q[2] <= wr_q[1];
      wr_q[3] <= wr_q[2];
    end
  end

  // cell bytes and earlier hashes carried down
  cell_t y1_q, z1_q, z2_q, w1_q, w2_q, w3_q;
  hash_t h1_d [2];
  hash_t h2_d [4];
  hash_t h3_d [8];
  hash_t h4_d [16];
  hash_t h1_s2_q [2];
  hash_t h1_s3_q [2];
  hash_t h1_s4_q [2];
  hash_t h2_s3_q [4];
  hash_t h2_s4_q [4];
  hash_t h3_s4_q [8];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      idx_q[1] <= index_i;
      idx_q[2] <= idx_q[1];
      idx_q[3] <= idx_q[2];
      val_q[1] <= value_i;
      val_q[2] <= val_q[1];
      val_q[3] <= val_q[2];
      y1_q <= cell_y_i;
      z1_q <= cell_z_i;
      z2_q <= z1_q;
      w1_q <= cell_w_i;
      w2_q <= w1_q;
      w3_q <= w2_q;
      h1_s2_q <= h1_d;
      h1_s3_q <= h1_s2_q;
      h1_s4_q <= h1_s3_q;
      h2_s3_q <= h2_d;
      h2_s4_q <= h2_s3_q;
      h3_s4_q <= h3_d;
    end
  end

  // level one: x corners
  gng_ram #(.WIDTH(8), .DEPTH(TableSize)) u_ram_l1 (
    .clk_i     (clk_i),
    .we_i      (adv_i & load_i),
    .waddr_i   (index_i),
    .wdata_i   (value_i),
    .re_i      (adv_i),
    .raddr_a_i (addr_t'(cell_x_i)),
    .raddr_b_i (addr_t'(cell_x_i + cell_t'(1))),
    .rdata_a_o (h1_d[0]),
    .rdata_b_o (h1_d[1])
  );

  // level two: y corners
  for (genvar j = 0; j < 2; j++) begin : g_l2
    localparam int CA = 2 * j;
    localparam int CB = 2 * j + 1;
    gng_ram #(.WIDTH(8), .DEPTH(TableSize)) u_ram (
      .clk_i     (clk_i),
      .we_i      (adv_i & wr_q[1]),
      .waddr_i   (idx_q[1]),
      .wdata_i   (val_q[1]),
      .re_i      (adv_i),
      .raddr_a_i (addr_t'(h1_d[CA % 2] + y1_q + hash_t'(CA / 2))),
      .raddr_b_i (addr_t'(h1_d[CB % 2] + y1_q + hash_t'(CB / 2))),
      .rdata_a_o (h2_d[CA]),
      .rdata_b_o (h2_d[CB])
    );
  end

  // level three: z corners
  for (genvar j = 0; j < 4; j++) begin : g_l3
    localparam int CA = 2 * j;
    localparam int CB = 2 * j + 1;
    gng_ram #(.WIDTH(8), .DEPTH(TableSize)) u_ram (
      .clk_i     (clk_i),
      .we_i      (adv_i & wr_q[2]),
      .waddr_i   (idx_q[2]),
      .wdata_i   (val_q[2]),
      .re_i      (adv_i),
      .raddr_a_i (addr_t'(h2_d[CA % 4] + z2_q + hash_t'(CA / 4))),
      .raddr_b_i (addr_t'(h2_d[CB % 4] + z2_q + hash_t'(CB / 4))),
      .rdata_a_o (h3_d[CA]),
      .rdata_b_o (h3_d[CB])
    );
  end

  // level four: w corners
  for (genvar j = 0; j < 8; j++) begin : g_l4
    localparam int CA = 2 * j;
    localparam int CB = 2 * j + 1;
    gng_ram #(.WIDTH(8), .DEPTH(TableSize)) u_ram (
      .clk_i     (clk_i),
      .we_i      (adv_i & wr_q[3]),
      .waddr_i   (idx_q[3]),
      .wdata_i   (val_q[3]),
      .re_i      (adv_i),
      .raddr_a_i (addr_t'(h3_d[CA % 8] + w3_q + hash_t'(CA / 8))),
      .raddr_b_i (addr_t'(h3_d[CB % 8] + w3_q + hash_t'(CB / 8))),
      .rdata_a_o (h4_d[CA]),
      .rdata_b_o (h4_d[CB])
    );
  end

  assign h1_o = h1_s4_q;
  assign h2_o = h2_s4_q;
  assign h3_o = h3_s4_q;
  assign h4_o = h4_d;

endmodule

### hdl/gng_fade.sv
// quintic fade of four fractions, one multiply per stage over four stages
// depends on gng_pkg
module gng_fade import gng_pkg::*; (
  input  logic  clk_i,
  input  logic  adv_i,
  input  frac_t frac_i [NumAxes],
  output fade_t fade_o [NumAxes]
);

  frac_t f2_q [NumAxes];
  frac_t f3_q [NumAxes];
  frac_t f4_q [NumAxes];
  fade_t r2_q [NumAxes];
  fade_t r3_q [NumAxes];
  fade_t r4_q [NumAxes];
  fade_t r5_q [NumAxes];

  // horner steps, one product per stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NumAxes; k++) begin
        r2_q[k] <= fade_mul(frac_i[k], fade_first(frac_i[k])) + Fade10;
        f2_q[k] <= frac_i[k];
        r3_q[k] <= fade_mul(f2_q[k], r2_q[k]);
        f3_q[k] <= f2_q[k];
        r4_q[k] <= fade_mul(f3_q[k], r3_q[k]);
        f4_q[k] <= f3_q[k];
        r5_q[k] <= fade_mul(f4_q[k], r4_q[k]);
      end
    end
  end

  assign fade_o = r5_q;

endmodule

### hdl/gng_blend.sv
// corner gradients and the interpolation tree, one axis per stage
// depends on gng_pkg
module gng_blend import gng_pkg::*; (
  input  logic  clk_i,
  input  logic  adv_i,
  input  dims_t dims_i,
  input  hash_t h1_i [2],
  input  hash_t h2_i [4],
  input  hash_t h3_i [8],
  input  hash_t h4_i [16],
  input  frac_t frac_i [NumAxes],
  input  fade_t fade_i [NumAxes],
  output val_t  sum_o
);

  val_t  grad_d [NumCorner];
  val_t  v5_q [NumCorner];
  val_t  v6_q [8];
  val_t  v7_q [4];
  val_t  v8_q [2];
  val_t  v9_q;
  fade_t fy6_q, fz6_q, fz7_q, fw6_q, fw7_q, fw8_q;

  // gradient of each corner; corners past the used axes repeat lower ones
  always_comb begin
    logic [3:0] cb;
    hash_t      h;
    val_t       d [NumAxes];
    for (int c = 0; c < NumCorner; c++) begin
      cb = 4'(c);
      case (dims_i)
        Dims1:   h = h1_i[cb[0]];
        Dims2:   h = h2_i[cb[1:0]];
        Dims3:   h = h3_i[cb[2:0]];
        default: h = h4_i[cb];
      endcase
      for (int k = 0; k < NumAxes; k++) begin
        d[k] = val_t'({1'b0, frac_i[k]}) - (cb[k] ? ValOne : val_t'(0));
      end
      grad_d[c] = grad_f(dims_i, h, d[0], d[1], d[2], d[3]);
    end
  end

  // interpolation stages x, y, z, w
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      v5_q <= grad_d;
      for (int i = 0; i < 8; i++) v6_q[i] <= lerp_f(v5_q[2*i], v5_q[2*i+1], fade_i[0]);
      for (int i = 0; i < 4; i++) v7_q[i] <= lerp_f(v6_q[2*i], v6_q[2*i+1], fy6_q);
      for (int i = 0; i < 2; i++) v8_q[i] <= lerp_f(v7_q[2*i], v7_q[2*i+1], fz7_q);
      v9_q  <= lerp_f(v8_q[0], v8_q[1], fw8_q);
      fy6_q <= fade_i[1];
      fz6_q <= fade_i[2];
      fz7_q <= fz6_q;
      fw6_q <= fade_i[3];
      fw7_q <= fw6_q;
      fw8_q <= fw7_q;
    end
  end

  assign sum_o = v9_q;

endmodule

### hdl/gradient_noise_generator_core.sv
// top level of the gradient noise generator: pipeline control and output stage
// depends on gng_pkg, gng_in_if, gng_out_if, gng_hash, gng_fade, gng_blend
//
//   channel   dir  handshake        payload
//   in_i      in   valid / ready    op, coord_x..coord_w, table_index, table_value
//   out_o     out  valid / ready    noise_value
//   cfg       in   cfg_we_i         cfg_wdata_i (dimensions)
//
// one request per cycle unless the output stalls; each evaluate passes the four
// chained lookups, the gradient register, four lerps and the output register
// reset clears valid bits and sets dimensions to 3; table contents stay unknown
// a stalled output holds the whole pipeline; nothing is lost or repeated
module gradient_noise_generator_core import gng_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  dims_t cfg_wdata_i,
  gng_in_if.sink    in_i,
  gng_out_if.source out_o
);

  dims_t  dims_q, dims_eff;
  logic   adv, take, ld, ev;
  logic   ev_q [1:9];
  logic   out_valid_q;
  noise_t noise_q;
  frac_t  frac1_q [NumAxes];
  frac_t  frac2_q [NumAxes];
  frac_t  frac3_q [NumAxes];
  frac_t  frac4_q [NumAxes];
  fade_t  fade5 [NumAxes];
  hash_t  h1 [2];
  hash_t  h2 [4];
  hash_t  h3 [8];
  hash_t  h4 [16];
  val_t   sum9;
  noise_t sat;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= DimsReset;
    end else if (cfg_we_i) begin
      dims_q <= cfg_wdata_i;
    end
  end

  // clamp to 1..4
  always_comb begin
    if (dims_q < Dims1)      dims_eff = Dims1;
    else if (dims_q > Dims4) dims_eff = Dims4;
    else                     dims_eff = dims_q;
  end

  // global advance
  assign adv      = ~out_valid_q | out_o.ready;
  assign in_i.ready = adv;
  assign take     = in_i.valid & adv;
  assign ld       = take & (op_e'(in_i.op) == OP_LOAD);
  assign ev       = take & (op_e'(in_i.op) == OP_EVAL);

  // evaluate valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= 9; s++) ev_q[s] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      ev_q[1] <= ev;
      for (int s = 2; s <= 9; s++) ev_q[s] <= ev_q[s-1];
      out_valid_q <= ev_q[9];
    end
  end

  // fractions carried to the gradient stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      frac1_q[0] <= in_i.coord_x[FracBits-1:0];
      frac1_q[1] <= in_i.coord_y[FracBits-1:0];
      frac1_q[2] <= in_i.coord_z[FracBits-1:0];
      frac1_q[3] <= in_i.coord_w[FracBits-1:0];
      frac2_q <= frac1_q;
      frac3_q <= frac2_q;
      frac4_q <= frac3_q;
    end
  end

  gng_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .load_i   (ld),
    .index_i  (addr_t'(in_i.table_index)),
    .value_i  (in_i.table_value),
    .cell_x_i (in_i.coord_x[CoordW-1:FracBits]),
    .cell_y_i (in_i.coord_y[CoordW-1:FracBits]),
    .cell_z_i (in_i.coord_z[CoordW-1:FracBits]),
    .cell_w_i (in_i.coord_w[CoordW-1:FracBits]),
    .h1_o     (h1),
    .h2_o     (h2),
    .h3_o     (h3),
    .h4_o     (h4)
  );

  gng_fade u_fade (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .frac_i (frac1_q),
    .fade_o (fade5)
  );

  gng_blend u_blend (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .dims_i (dims_eff),
    .h1_i   (h1),
    .h2_i   (h2),
    .h3_i   (h3),
    .h4_i   (h4),
    .frac_i (frac4_q),
    .fade_i (fade5),
    .sum_o  (sum9)
  );

  // saturate to the output range
  always_comb begin
    if (sum9 > OutMax)      sat = OutMax[OutW-1:0];
    else if (sum9 < OutMin) sat = OutMin[OutW-1:0];
    else                    sat = sum9[OutW-1:0];
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      noise_q <= sat;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.noise_value = noise_q;

endmodule
